// ===== hw/rtl/spq_pkg.sv =====
// Package: shared types and constants of the supply polarity qualifier.
package spq_pkg;

    localparam int unsigned SAMPLE_CODE_W = 3;
    localparam int unsigned STATE_W       = 3;
    localparam int unsigned COUNT_W       = 16;

    localparam logic [COUNT_W-1:0] CONFIRM_COUNT_RESET = 16'd2000;

    // Classified sample codes
    localparam logic [SAMPLE_CODE_W-1:0] SC_POS  = 3'd0;
    localparam logic [SAMPLE_CODE_W-1:0] SC_NEG  = 3'd1;
    localparam logic [SAMPLE_CODE_W-1:0] SC_DOWN = 3'd2;
    localparam logic [SAMPLE_CODE_W-1:0] SC_ERR  = 3'd3;

    typedef enum logic [STATE_W-1:0] {
        ST_DOWN  = 3'd0,
        ST_UNDET = 3'd1,
        ST_POS   = 3'd2,
        ST_NEG   = 3'd3,
        ST_P2N   = 3'd4,
        ST_N2P   = 3'd5,
        ST_ERR   = 3'd6
    } supply_state_t;

    typedef struct packed {
        logic [STATE_W-1:0] supply_state;
        logic               polarity_valid;
        logic               advance;
    } spq_result_t;

endpackage

// ===== hw/rtl/spq_if.sv =====
// Interfaces: sample and result channels of the supply polarity qualifier.
interface spq_sample_if;
    logic       valid;
    logic       ready;
    logic [2:0] sample_code;
    logic       sample_valid;

    modport source (output valid, output sample_code, output sample_valid, input ready);
    modport sink   (input valid, input sample_code, input sample_valid, output ready);
endinterface

interface spq_result_if;
    logic       valid;
    logic       ready;
    logic [2:0] supply_state;
    logic       polarity_valid;
    logic       advance;

    modport source (output valid, output supply_state, output polarity_valid,
                    output advance, input ready);
    modport sink   (input valid, input supply_state, input polarity_valid,
                    input advance, output ready);
endinterface

// ===== hw/rtl/supply_polarity_qualifier_top.sv =====
// Top level: supply polarity qualifier with input and result registers.
//
// Usage:
//   samples  - sink channel, one beat per classified polarity sample
//              (sample_code, sample_valid). Taken when valid and ready.
//   results  - source channel, exactly one beat per sample beat
//              (supply_state, polarity_valid, advance), in order.
//   cfg_wr_en / cfg_wr_data - write of confirm_count, taken at any edge
//              with cfg_wr_en high; write it only while no beats are in flight.
// Pipeline: an accepted sample beat loads the input register, then the state
//   update loads the result register, which offers its result beat (one input
//   register, one result register). Throughput: one beat per cycle while
//   results.ready is high; the update is a single pass of logic between them.
// Stall: while results.ready is low the result register holds; the input
//   register still fills, then samples.ready drops until the result moves.
// Reset: state returns to undetermined, reversal count and valid flag to
//   zero, confirm_count to 2000, and both registers empty.
module supply_polarity_qualifier_top (
    input  logic                 clk,
    input  logic                 rst_n,
    spq_sample_if.sink           samples,
    spq_result_if.source         results,
    input  logic                 cfg_wr_en,
    input  logic [15:0]          cfg_wr_data
);
    import spq_pkg::*;

    logic                      in_valid_reg;
    logic [SAMPLE_CODE_W-1:0]  in_code_reg;
    logic                      in_sv_reg;
    logic                      out_valid_reg;
    spq_result_t               out_reg;
    logic [COUNT_W-1:0]        confirm_count_reg;
    logic                      step;
    spq_result_t               result;

    // Advance the input beat into the result register when that slot frees up
    assign step          = in_valid_reg && (!out_valid_reg || results.ready);
    assign samples.ready = !in_valid_reg || step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            confirm_count_reg <= CONFIRM_COUNT_RESET;
        end
        else if (cfg_wr_en)
        begin
            confirm_count_reg <= cfg_wr_data;
        end
    end

    // Input register: load a new beat whenever the slot is free or draining
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (samples.ready)
        begin
            in_valid_reg <= samples.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (samples.valid && samples.ready)
        begin
            in_code_reg <= samples.sample_code;
            in_sv_reg   <= samples.sample_valid;
        end
    end

    spq_update u_update (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step),
        .sample_code   (in_code_reg),
        .sample_valid  (in_sv_reg),
        .confirm_count (confirm_count_reg),
        .result        (result)
    );

    // Result register: hold while the receiver stalls, drop once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_reg <= result;
        end
    end

    assign results.valid          = out_valid_reg;
    assign results.supply_state   = out_reg.supply_state;
    assign results.polarity_valid = out_reg.polarity_valid;
    assign results.advance        = out_reg.advance;

endmodule

// ===== hw/rtl/spq_update.sv =====
// Qualifier state registers and the per-sample state update.
module spq_update (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         step,
    input  logic [spq_pkg::SAMPLE_CODE_W-1:0] sample_code,
    input  logic                         sample_valid,
    input  logic [spq_pkg::COUNT_W-1:0]  confirm_count,
    output spq_pkg::spq_result_t         result
);
    import spq_pkg::*;

    supply_state_t        state_reg, state_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic                 flag_reg, flag_next;
    logic [COUNT_W-1:0]   count_inc;
    logic                 confirmed;
    logic                 adv;
    logic                 processed;

    // Saturating increment of the reversal count
    assign count_inc = (count_reg != {COUNT_W{1'b1}}) ? count_reg + 1'b1 : count_reg;
    assign confirmed = (count_inc >= confirm_count);
    assign processed = step && sample_valid && !sample_code[2];

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        flag_next  = flag_reg;
        adv        = 1'b0;
        if (processed)
        begin
            flag_next = 1'b0;
            unique case (state_reg)
                ST_DOWN, ST_UNDET:
                begin
                    if (sample_code == SC_POS || sample_code == SC_NEG)
                    begin
                        state_next = (sample_code == SC_POS) ? ST_POS : ST_NEG;
                        flag_next  = 1'b1;
                        adv        = 1'b1;
                    end
                    else if (sample_code == SC_ERR)
                    begin
                        state_next = ST_ERR;
                        adv        = 1'b1;
                    end
                    else if (state_reg == ST_DOWN)
                    begin
                        adv = 1'b1;
                    end
                end
                ST_POS, ST_NEG:
                begin
                    if (sample_code == SC_ERR)
                    begin
                        state_next = ST_ERR;
                        adv        = 1'b1;
                    end
                    else if (sample_code == SC_DOWN)
                    begin
                        state_next = ST_DOWN;
                        adv        = 1'b1;
                    end
                    else if ((state_reg == ST_POS) == (sample_code == SC_POS))
                    begin
                        flag_next = 1'b1;
                        adv       = 1'b1;
                    end
                    else
                    begin
                        state_next = (state_reg == ST_POS) ? ST_P2N : ST_N2P;
                        count_next = '0;
                    end
                end
                ST_P2N:
                begin
                    if (sample_code == SC_NEG)
                    begin
                        count_next = count_inc;
                        adv        = 1'b1;
                        if (confirmed)
                        begin
                            state_next = ST_NEG;
                            flag_next  = 1'b1;
                        end
                    end
                    else if (sample_code == SC_POS)
                    begin
                        count_next = '0;
                        state_next = ST_N2P;
                    end
                end
                ST_N2P:
                begin
                    if (sample_code == SC_POS)
                    begin
                        count_next = count_inc;
                        adv        = 1'b1;
                        if (confirmed)
                        begin
                            state_next = ST_POS;
                            flag_next  = 1'b1;
                        end
                    end
                    else if (sample_code == SC_NEG)
                    begin
                        count_next = '0;
                        state_next = ST_P2N;
                    end
                end
                default:
                begin
                    // error is sticky: only the flag drops
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_UNDET;
            count_reg <= '0;
            flag_reg  <= 1'b0;
        end
        else if (step)
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            flag_reg  <= flag_next;
        end
    end

    assign result.supply_state   = state_next;
    assign result.polarity_valid = flag_next;
    assign result.advance        = adv;

endmodule

// ===== tb/polarity_checker.sv =====
// Checker: predicts supply polarity qualifier results and compares each result beat.
`timescale 1ns / 100ps

module polarity_checker (
    input  logic        clk,
    input  logic        rst_n,
    spq_sample_if       samples,
    spq_result_if       results,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    output int          mismatches,
    output int          results_owed
);
    import spq_pkg::*;

    localparam int MAX_REPORTS = 10;

    logic [COUNT_W-1:0] confirm_target;
    supply_state_t      qual_state;
    logic [COUNT_W-1:0] run_length;
    logic               accepted_flag;
    spq_result_t        owed_q[$];

    // Count one confirming sample; take the target polarity once confirmed.
    function automatic void count_confirm(input supply_state_t target);
        if (run_length != '1)
            run_length = run_length + 1'b1;
        if (run_length >= confirm_target)
        begin
            qual_state    = target;
            accepted_flag = 1'b1;
        end
    endfunction

    function automatic spq_result_t qualify_sample(input logic [2:0] code, input logic sv);
        logic        adv;
        spq_result_t res;
        adv = 1'b0;
        if (sv && code <= SC_ERR)
        begin
            accepted_flag = 1'b0;
            case (qual_state)
                ST_DOWN, ST_UNDET:
                begin
                    if (code == SC_POS)
                    begin
                        qual_state    = ST_POS;
                        accepted_flag = 1'b1;
                        adv           = 1'b1;
                    end
                    else if (code == SC_NEG)
                    begin
                        qual_state    = ST_NEG;
                        accepted_flag = 1'b1;
                        adv           = 1'b1;
                    end
                    else if (code == SC_ERR)
                    begin
                        qual_state = ST_ERR;
                        adv        = 1'b1;
                    end
                    else
                        adv = (qual_state == ST_DOWN);
                end
                ST_POS, ST_NEG:
                begin
                    if (code == SC_ERR)
                    begin
                        qual_state = ST_ERR;
                        adv        = 1'b1;
                    end
                    else if (code == SC_DOWN)
                    begin
                        qual_state = ST_DOWN;
                        adv        = 1'b1;
                    end
                    else if ((qual_state == ST_POS) == (code == SC_POS))
                    begin
                        accepted_flag = 1'b1;
                        adv           = 1'b1;
                    end
                    else
                    begin
                        if (qual_state == ST_POS)
                            qual_state = ST_P2N;
                        else
                            qual_state = ST_N2P;
                        run_length = '0;
                    end
                end
                ST_P2N:
                begin
                    if (code == SC_NEG)
                    begin
                        count_confirm(ST_NEG);
                        adv = 1'b1;
                    end
                    else if (code == SC_POS)
                    begin
                        run_length = '0;
                        qual_state = ST_N2P;
                    end
                end
                ST_N2P:
                begin
                    if (code == SC_POS)
                    begin
                        count_confirm(ST_POS);
                        adv = 1'b1;
                    end
                    else if (code == SC_NEG)
                    begin
                        run_length = '0;
                        qual_state = ST_P2N;
                    end
                end
                default:
                begin
                end
            endcase
        end
        res.supply_state   = qual_state;
        res.polarity_valid = accepted_flag;
        res.advance        = adv;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch_beats
        spq_result_t want;
        if (!rst_n)
        begin
            confirm_target = CONFIRM_COUNT_RESET;
            qual_state     = ST_UNDET;
            run_length     = '0;
            accepted_flag  = 1'b0;
            owed_q.delete();
            mismatches     = 0;
            results_owed   = 0;
        end
        else
        begin
            if (cfg_wr_en)
                confirm_target = cfg_wr_data;
            if (samples.valid && samples.ready)
                owed_q.push_back(qualify_sample(samples.sample_code, samples.sample_valid));
            if (results.valid && results.ready)
            begin
                if (owed_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("unexpected result beat: state %0d valid %0b advance %0b",
                                 results.supply_state, results.polarity_valid,
                                 results.advance);
                end
                else
                begin
                    want = owed_q.pop_front();
                    if (results.supply_state !== want.supply_state ||
                        results.polarity_valid !== want.polarity_valid ||
                        results.advance !== want.advance)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display({"result mismatch: expected state %0d valid %0b ",
                                      "advance %0b, got state %0d valid %0b advance %0b"},
                                     want.supply_state, want.polarity_valid, want.advance,
                                     results.supply_state, results.polarity_valid,
                                     results.advance);
                    end
                end
            end
            results_owed = owed_q.size();
        end
    end

endmodule

// ===== tb/supply_polarity_qualifier_top_test.sv =====
// Testbench top: drives samples and confirm_count writes and reports the verdict.
`timescale 1ns / 100ps

module supply_polarity_qualifier_top_test;
    import spq_pkg::*;

    // Sample code that the block treats as undetermined and ignores.
    localparam logic [SAMPLE_CODE_W-1:0] SC_UNDET = 3'd4;
    localparam int RX_HOLD_CYCLES = 64;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [15:0] cfg_wr_data = '0;

    int tx_idle_pct   = 0;   // percent of cycles the sender sits idle before a beat
    int rx_idle_pct   = 0;   // percent of cycles the receiver holds ready low
    int hold_requests = 0;   // bump to ask the receiver for one long hold-off
    int items_sent    = 0;
    int mismatches;
    int results_owed;

    spq_sample_if sample_ch ();
    spq_result_if result_ch ();

    supply_polarity_qualifier_top u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .samples     (sample_ch),
        .results     (result_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    polarity_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .samples      (sample_ch),
        .results      (result_ch),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .mismatches   (mismatches),
        .results_owed (results_owed)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Offer one sample beat; call at a falling edge, return at the falling edge
    // after the beat is taken. Idle cycles drop valid first, at random.
    task automatic send_sample(input logic [2:0] code, input logic sv);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            sample_ch.valid <= 1'b0;
            @(negedge clk);
        end
        sample_ch.valid        <= 1'b1;
        sample_ch.sample_code  <= code;
        sample_ch.sample_valid <= sv;
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
        @(negedge clk);
        items_sent++;
    endtask

    // Send a beat the block must ignore: sampler data not valid, or a code
    // beyond error (undetermined and the unused codes).
    task automatic send_noise();
        if ($urandom_range(1))
            send_sample(3'($urandom_range(7)), 1'b0);
        else
            send_sample(3'($urandom_range(7, SC_UNDET)), 1'b1);
    endtask

    // Drop valid and hold until every owed result beat has come back, then
    // let the pipeline settle.
    task automatic wait_for_results();
        sample_ch.valid <= 1'b0;
        while (results_owed != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Write confirm_count while nothing is in flight.
    task automatic write_confirm(input logic [15:0] value);
        wait_for_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
    endtask

    // One well-formed reversal episode with random content. ceff is the
    // effective confirm count (zero behaves as one).
    task automatic run_sequence(input int ceff);
        logic [2:0] toward;   // polarity being confirmed
        logic [2:0] away;     // polarity being left
        int         run;
        int         steps;
        int         pick;
        // Scramble with a few stray beats; no error code here, since an
        // error in a settled state would latch for the rest of the run.
        repeat ($urandom_range(3))
        begin
            pick = $urandom_range(3);
            case (pick)
                0: send_sample(SC_POS, 1'b1);
                1: send_sample(SC_NEG, 1'b1);
                2: send_sample(SC_DOWN, 1'b1);
                default: send_noise();
            endcase
        end
        // Enough positive beats settle on positive from any non-error state.
        repeat (ceff + 1) send_sample(SC_POS, 1'b1);
        away = SC_POS;
        // Sometimes pass through power down and re-acquire either polarity.
        if ($urandom_range(2) == 0)
        begin
            repeat ($urandom_range(2, 1)) send_sample(SC_DOWN, 1'b1);
            away = $urandom_range(1) ? SC_POS : SC_NEG;
            send_sample(away, 1'b1);
        end
        repeat ($urandom_range(2)) send_sample(away, 1'b1);
        // Open a reversal and walk it. Down and error are safe only while
        // the reversal is still unconfirmed, so stop once it is accepted.
        toward = (away == SC_POS) ? SC_NEG : SC_POS;
        send_sample(toward, 1'b1);
        run   = 0;
        steps = $urandom_range(2 * ceff + 4, 1);
        while (steps > 0 && run < ceff)
        begin
            pick = $urandom_range(99);
            if (pick < 50)
            begin
                send_sample(toward, 1'b1);
                run++;
            end
            else if (pick < 62)
            begin
                // bounce back: direction turns round and the count clears
                send_sample(away, 1'b1);
                {toward, away} = {away, toward};
                run = 0;
            end
            else if (pick < 72)
                send_sample(SC_DOWN, 1'b1);
            else if (pick < 82)
                send_sample(SC_ERR, 1'b1);
            else
                send_noise();
            steps--;
        end
    endtask

    // One random phase: set confirm_count and idling, optionally ask for a
    // long receiver hold-off, then run episodes until enough beats went out.
    task automatic run_phase(input int n, input logic [15:0] confirm,
                             input int tx_pct, input int rx_pct, input logic hold);
        int first;
        write_confirm(confirm);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        if (hold)
            hold_requests++;
        first = items_sent;
        while (items_sent - first < n)
            run_sequence((confirm == 0) ? 1 : int'(confirm));
    endtask

    // Receiver: random ready, plus a long hold-off counted here on request.
    initial
    begin : result_receiver
        int hold_left    = 0;
        int holds_served = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (holds_served != hold_requests)
            begin
                hold_left    = RX_HOLD_CYCLES;
                holds_served = hold_requests;
            end
            if (hold_left > 0)
            begin
                result_ch.ready <= 1'b0;
                hold_left--;
            end
            else
                result_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Stimulus and verdict.
    initial
    begin
        sample_ch.valid        = 1'b0;
        sample_ch.sample_code  = '0;
        sample_ch.sample_valid = 1'b0;
        result_ch.ready        = 1'b0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed walk with confirm_count of three.
        write_confirm(16'd3);
        send_sample(SC_POS, 1'b0);       // sampler data not valid: ignored
        send_sample(SC_UNDET, 1'b1);     // undetermined: ignored
        send_sample(3'd7, 1'b1);         // top unused code: ignored
        send_sample(SC_DOWN, 1'b1);      // down while undetermined: no advance
        send_sample(SC_POS, 1'b1);       // accept positive at once
        send_sample(3'd5, 1'b0);         // ignored beat repeats the valid flag
        send_sample(SC_POS, 1'b1);       // same polarity: confirmed again
        send_sample(SC_NEG, 1'b1);       // open a reversal toward negative
        send_sample(SC_NEG, 1'b1);
        send_sample(SC_DOWN, 1'b1);      // down during reversal: flag cleared only
        send_sample(SC_ERR, 1'b1);       // error during reversal: not latched
        send_sample(SC_POS, 1'b1);       // bounce back toward positive
        repeat (3) send_sample(SC_POS, 1'b1);   // third beat accepts positive
        send_sample(SC_DOWN, 1'b1);      // stable to down
        send_sample(SC_DOWN, 1'b1);      // down while down advances
        send_sample(SC_NEG, 1'b1);       // accept negative from down
        send_sample(3'd6, 1'b1);         // ignored
        send_sample(SC_POS, 1'b1);       // reversal toward positive
        send_sample(SC_NEG, 1'b1);       // bounce toward negative
        repeat (3) send_sample(SC_NEG, 1'b1);

        // Zero confirm_count acts as one: first confirming beat accepts.
        write_confirm(16'd0);
        send_sample(SC_POS, 1'b1);
        send_sample(SC_POS, 1'b1);
        write_confirm(16'd1);
        send_sample(SC_NEG, 1'b1);
        send_sample(SC_NEG, 1'b1);

        // Random phases: sender light and receiver heavy idling, then the
        // other way round, then back to back with one long receiver hold-off
        // so the block fills and stalls its input.
        run_phase(230, 16'd1, 25, 80, 1'b0);
        run_phase(230, 16'd5, 80, 25, 1'b0);
        run_phase(230, 16'd2, 0, 0, 1'b1);

        // Widest count: settle on positive, then walk a reversal that stays
        // unconfirmed; a smaller count then accepts it on the next beat.
        repeat (3) send_sample(SC_POS, 1'b1);
        write_confirm(16'hFFFF);
        send_sample(SC_NEG, 1'b1);
        repeat (8) send_sample(SC_NEG, 1'b1);
        write_confirm(16'd1);
        send_sample(SC_NEG, 1'b1);

        // Error from a stable polarity latches for good; probe it last.
        send_sample(SC_ERR, 1'b1);
        repeat (16) send_sample(3'($urandom_range(7)), 1'($urandom_range(1)));

        wait_for_results();
        repeat (8) @(negedge clk);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #2000000;
        $display("status: fail");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/spq_pkg.sv
hw/rtl/spq_if.sv
hw/rtl/spq_update.sv
hw/rtl/supply_polarity_qualifier_top.sv
tb/polarity_checker.sv
tb/supply_polarity_qualifier_top_test.sv
